// File: hw/rtl/pidc_pkg.sv
// Shared types and constants of the clipped PID controller.
`default_nettype none

package pidc_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MP,
    ST_MI,
    ST_ML,
    ST_MH,
    ST_MD,
    ST_ACC,
    ST_ISUM,
    ST_DWAIT,
    ST_DSUM,
    ST_CLAMP,
    ST_FIN
  } pidc_state_e;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_P_GAIN     = 3'd0,
    CFG_I_GAIN     = 3'd1,
    CFG_I_CLIP_PRE = 3'd2,
    CFG_I_CLIP     = 3'd3,
    CFG_D_GAIN     = 3'd4,
    CFG_D_CLIP     = 3'd5,
    CFG_OUT_MIN    = 3'd6,
    CFG_OUT_MAX    = 3'd7
  } pidc_cfg_e;

  // Item function codes.
  typedef enum logic {
    FUNC_UPDATE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } pidc_func_e;

  // Smallest time step that yields a derivative term (about 1 us in Q8.24).
  localparam logic [31:0] DT_MIN = 32'd17;

  // Quotient bits produced by the serial divider.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Reset values of the output clamps (+-10000.0 in Q16.16).
  localparam logic signed [31:0] OUT_MIN_RST = -32'sd655360000;
  localparam logic signed [31:0] OUT_MAX_RST = 32'sd655360000;
  localparam logic signed [31:0] P_GAIN_RST  = 32'sd65536;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic done;
    logic sat;
  } pidc_div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pidc_if.sv
// Handshake channels of the clipped PID controller: items, results, configuration.
`default_nettype none

interface pidc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] error_value;
  logic        [31:0] step_time;

  modport source (output valid, func, error_value, step_time, input ready);
  modport sink   (input valid, func, error_value, step_time, output ready);
endinterface

interface pidc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pidc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pidc_div.sv
// Radix-2 restoring divider with overflow detection, one quotient bit per cycle.
`default_nettype none

module pidc_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [71:0]              dividend_i,
  input  wire logic [31:0]              divisor_i,
  output logic      [31:0]              quot_o,
  output pidc_pkg::pidc_div_stat_t      stat_o
);

  logic                            busy_q, busy_d;
  logic [pidc_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            sat_q, sat_d;
  logic [31:0]                     rem_q, rem_d;
  logic [31:0]                     quo_q, quo_d;
  logic [31:0]                     den_q, den_d;
  logic [32:0]                     trial;
  logic [32:0]                     diff;
  logic                            fits;

  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sat_d  = sat_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      // quotient needs more than 32 bits when the top part already reaches the divisor
      busy_d = 1'b1;
      cnt_d  = pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS);
      sat_d  = (dividend_i[71:32] >= {8'd0, divisor_i});
      rem_d  = dividend_i[63:32];
      quo_d  = dividend_i[31:0];
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = fits ? diff[31:0] : trial[31:0];
        quo_d = {quo_q[30:0], fits};
        cnt_d = cnt_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quot_o      = quo_q;
  assign stat_o.done = busy_q && (cnt_q == '0);
  assign stat_o.sat  = sat_q;

endmodule

`default_nettype wire

// File: hw/rtl/pid_controller_clipped.sv
// Top level of the clipped PID controller: register file, sequencer, shared multiplier.
//
// Usage:
//   cfg_i    write channel; a beat writes register cfg_i.index with cfg_i.data.
//            Always ready. Write only while the block is idle.
//   item_i   input beats. func = update carries error_value (Q16.16) and
//            step_time (Q8.24 s); func = clear zeroes the integrator and gives no result.
//   result_o one beat per update: drive, the clamped output in Q16.16.
// Sequence:
//   A clear beat leaves the block idle, ready for the next item. An update occupies
//   the block for five passes through one shared 33x33 multiplier, then a 32-step
//   serial divider for the derivative term, then sum, clamp and rounding.
//   item_i.ready is low while an update is in flight.
// Reset:
//   Asynchronous, active low. Gains, limits and clamps return to their defaults
//   (p_gain 1.0, clamps +-10000.0, all else 0); integrator and previous error clear.
// Stall:
//   The result sits in an output register. A new item is accepted while it waits;
//   the sequencer holds the next result in its last step until the register frees.
`default_nettype none

module pid_controller_clipped (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pidc_cfg_if.sink   cfg_i,
  pidc_in_if.sink    item_i,
  pidc_out_if.source result_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] p_gain_q, i_gain_q, d_gain_q, out_min_q, out_max_q;
  logic        [30:0] i_clip_pre_q, i_clip_q, d_clip_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q     <= pidc_pkg::P_GAIN_RST;
      i_gain_q     <= '0;
      i_clip_pre_q <= '0;
      i_clip_q     <= '0;
      d_gain_q     <= '0;
      d_clip_q     <= '0;
      out_min_q    <= pidc_pkg::OUT_MIN_RST;
      out_max_q    <= pidc_pkg::OUT_MAX_RST;
    end else if (cfg_i.valid) begin
      case (pidc_pkg::pidc_cfg_e'(cfg_i.index))
        pidc_pkg::CFG_P_GAIN:     p_gain_q     <= cfg_i.data;
        pidc_pkg::CFG_I_GAIN:     i_gain_q     <= cfg_i.data;
        pidc_pkg::CFG_I_CLIP_PRE: i_clip_pre_q <= cfg_i.data[30:0];
        pidc_pkg::CFG_I_CLIP:     i_clip_q     <= cfg_i.data[30:0];
        pidc_pkg::CFG_D_GAIN:     d_gain_q     <= cfg_i.data;
        pidc_pkg::CFG_D_CLIP:     d_clip_q     <= cfg_i.data[30:0];
        pidc_pkg::CFG_OUT_MIN:    out_min_q    <= cfg_i.data;
        pidc_pkg::CFG_OUT_MAX:    out_max_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  pidc_pkg::pidc_state_e state_q, state_d;
  pidc_pkg::pidc_div_stat_t div_stat;

  logic item_acc;
  logic out_free;
  logic div_start;
  logic fin_load;
  logic signed [32:0] mul_a, mul_b;

  // item payload and per-item values
  logic signed [31:0] err_q;
  logic        [31:0] dt_q;
  logic signed [31:0] acc_q, prev_q;
  logic signed [65:0] sum_q;
  logic signed [63:0] prod_q;
  logic        [31:0] mi_hi_q, lo_hi_q;
  logic signed [31:0] inc_q, dterm_q;
  logic               d_neg_q, diff_top_q;
  logic               out_valid_q;
  logic signed [31:0] drive_q;

  assign item_acc = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pidc_pkg::ST_IDLE: begin
        if (item_acc && (pidc_pkg::pidc_func_e'(item_i.func) == pidc_pkg::FUNC_UPDATE)) begin
          state_d = pidc_pkg::ST_MP;
        end
      end
      pidc_pkg::ST_MP:    state_d = pidc_pkg::ST_MI;
      pidc_pkg::ST_MI:    state_d = pidc_pkg::ST_ML;
      pidc_pkg::ST_ML:    state_d = pidc_pkg::ST_MH;
      pidc_pkg::ST_MH:    state_d = pidc_pkg::ST_MD;
      pidc_pkg::ST_MD:    state_d = pidc_pkg::ST_ACC;
      pidc_pkg::ST_ACC:   state_d = pidc_pkg::ST_ISUM;
      pidc_pkg::ST_ISUM:  state_d = pidc_pkg::ST_DWAIT;
      pidc_pkg::ST_DWAIT: begin
        if (div_stat.done) begin
          state_d = pidc_pkg::ST_DSUM;
        end
      end
      pidc_pkg::ST_DSUM:  state_d = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: state_d = pidc_pkg::ST_FIN;
      pidc_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = pidc_pkg::ST_IDLE;
        end
      end
      default: state_d = pidc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // magnitudes of the signed operands
  logic        [31:0] e_mag, ig_mag, dg_mag;
  logic signed [32:0] diff;
  logic        [32:0] diff_mag;

  assign e_mag    = err_q[31]    ? (~err_q + 32'd1)    : err_q;
  assign ig_mag   = i_gain_q[31] ? (~i_gain_q + 32'd1) : i_gain_q;
  assign dg_mag   = d_gain_q[31] ? (~d_gain_q + 32'd1) : d_gain_q;
  assign diff     = {err_q[31], err_q} - {prev_q[31], prev_q};
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

  // Control outputs and multiplier operand steering.
  always_comb begin
    item_i.ready = 1'b0;
    div_start    = 1'b0;
    fin_load     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state_q)
      pidc_pkg::ST_IDLE: item_i.ready = 1'b1;
      pidc_pkg::ST_MP: begin
        // proportional term, signed
        mul_a = {p_gain_q[31], p_gain_q};
        mul_b = {err_q[31], err_q};
      end
      pidc_pkg::ST_MI: begin
        mul_a = {1'b0, ig_mag};
        mul_b = {1'b0, e_mag};
      end
      pidc_pkg::ST_ML: begin
        // low half of |i_gain*error| times dt
        mul_a = {1'b0, prod_q[31:0]};
        mul_b = {1'b0, dt_q};
      end
      pidc_pkg::ST_MH: begin
        mul_a = {1'b0, mi_hi_q};
        mul_b = {1'b0, dt_q};
      end
      pidc_pkg::ST_MD: begin
        mul_a = {1'b0, dg_mag};
        mul_b = {1'b0, diff_mag[31:0]};
      end
      pidc_pkg::ST_ACC: div_start = 1'b1;
      pidc_pkg::ST_FIN: fin_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier, registered product
  // ---------------------------------------------------------------------------
  logic signed [65:0] mul_full;

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
  end

  // ---------------------------------------------------------------------------
  // Integrator increment: (hi*dt + (lo*dt >> 32)) >> 8, clipped to i_clip_pre
  // ---------------------------------------------------------------------------
  logic [63:0] isum;
  logic [55:0] iq;
  logic [30:0] inc_mag;
  logic signed [31:0] inc_val;

  assign isum    = prod_q + {32'd0, lo_hi_q};
  assign iq      = isum[63:8];
  assign inc_mag = (iq > {25'd0, i_clip_pre_q}) ? i_clip_pre_q : iq[30:0];
  assign inc_val = (i_gain_q[31] ^ err_q[31]) ? -$signed({1'b0, inc_mag})
                                              :  $signed({1'b0, inc_mag});

  // Accumulator update, clipped to i_clip.
  logic signed [32:0] acc_sum;
  logic        [32:0] acc_mag;
  logic        [30:0] acc_clip;
  logic signed [31:0] acc_new;

  assign acc_sum  = {acc_q[31], acc_q} + {inc_q[31], inc_q};
  assign acc_mag  = acc_sum[32] ? (~acc_sum + 33'd1) : acc_sum;
  assign acc_clip = (acc_mag > {2'd0, i_clip_q}) ? i_clip_q : acc_mag[30:0];
  assign acc_new  = acc_sum[32] ? -$signed({1'b0, acc_clip}) : $signed({1'b0, acc_clip});

  // Derivative numerator: |d_gain|*|diff| in Q32.32, scaled by 256 for the Q8.24 divide.
  logic [63:0] dnum;
  logic [31:0] div_quot;

  assign dnum = prod_q + (diff_top_q ? {dg_mag, 32'd0} : 64'd0);

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({dnum, 8'd0}),
    .divisor_i  (dt_q),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  logic [30:0] d_mag;
  logic signed [31:0] d_val;

  assign d_mag = (div_stat.sat || (div_quot > {1'b0, d_clip_q})) ? d_clip_q : div_quot[30:0];
  assign d_val = (dt_q < pidc_pkg::DT_MIN) ? 32'sd0 :
                 (d_neg_q ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag}));

  // Output clamp on the Q32.32 sum; lower bound first, then upper.
  logic signed [65:0] lo_bound, hi_bound, clamp_lo, clamp_hi;
  logic signed [31:0] drive_val;
  logic               round_up;

  assign lo_bound  = {{18{out_min_q[31]}}, out_min_q, 16'd0};
  assign hi_bound  = {{18{out_max_q[31]}}, out_max_q, 16'd0};
  assign clamp_lo  = (sum_q < lo_bound) ? lo_bound : sum_q;
  assign clamp_hi  = (clamp_lo > hi_bound) ? hi_bound : clamp_lo;
  // truncate toward zero: bump a negative value with a nonzero fraction
  assign round_up  = sum_q[65] && (sum_q[15:0] != 16'd0);
  assign drive_val = sum_q[47:16] + {31'd0, round_up};

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      pidc_pkg::ST_IDLE: begin
        if (item_acc) begin
          err_q <= item_i.error_value;
          dt_q  <= item_i.step_time;
        end
      end
      pidc_pkg::ST_MI:    sum_q   <= {{2{prod_q[63]}}, prod_q};
      pidc_pkg::ST_ML:    mi_hi_q <= prod_q[63:32];
      pidc_pkg::ST_MH:    lo_hi_q <= prod_q[63:32];
      pidc_pkg::ST_MD: begin
        inc_q      <= inc_val;
        d_neg_q    <= d_gain_q[31] ^ diff[32];
        diff_top_q <= diff_mag[32];
      end
      pidc_pkg::ST_ISUM:  sum_q <= sum_q + {{18{acc_q[31]}}, acc_q, 16'd0};
      pidc_pkg::ST_DWAIT: dterm_q <= d_val;
      pidc_pkg::ST_DSUM:  sum_q <= sum_q + {{18{dterm_q[31]}}, dterm_q, 16'd0};
      pidc_pkg::ST_CLAMP: sum_q <= clamp_hi;
      default: ;
    endcase
  end

  // Integrator and previous error: both cleared by reset; a clear beat clears the integrator only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prev_q <= '0;
    end else if (item_acc && (pidc_pkg::pidc_func_e'(item_i.func) == pidc_pkg::FUNC_CLEAR)) begin
      acc_q <= '0;
    end else if (state_q == pidc_pkg::ST_ACC) begin
      acc_q  <= acc_new;
      prev_q <= err_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      drive_q <= drive_val;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.drive = drive_q;

`ifndef NO_ASSERTIONS
  // A new result only comes out of the final sequencer step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pidc_pkg::ST_FIN))
    else $error("result raised outside the final step");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == pidc_pkg::ST_DWAIT))
    else $error("divider done outside the wait step");

  // A clear beat leaves the integrator at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc && item_i.func) |=> (acc_q == 32'sd0))
    else $error("integrator not cleared");
`endif

endmodule

`default_nettype wire
